### rtl/core/rc5pd_pkg.sv
// constants, types and helpers shared by the rc5 pulse decoder
`default_nettype none

package rc5pd_pkg;

    localparam int UNIT_W  = 22;
    localparam int TOL_W   = 24;
    localparam int CFG_W   = 24;
    localparam int CODE_W  = 20;
    localparam int CNT_W   = 5;
    localparam int BOUND_W = 26;
    localparam int OUT_TDATA_W = ((CODE_W + 7) / 8) * 8;

    localparam logic [UNIT_W-1:0] UNIT_RESET = 22'd889;
    localparam logic [TOL_W-1:0]  TOL_RESET  = 24'd300;

    localparam logic [CNT_W-1:0] EXT_GAP_BITS   = 5'd8;
    localparam logic [CNT_W-1:0] STD_FRAME_BITS = 5'd14;
    localparam logic [CNT_W-1:0] EXT_FRAME_BITS = 5'd20;

    typedef enum logic {
        REG_UNIT_LENGTH = 1'b0,
        REG_TOLERANCE   = 1'b1
    } cfg_reg_t;

    // acceptance window around a multiple of the unit length
    typedef struct packed {
        logic               lo_neg;
        logic [BOUND_W-1:0] lo;
        logic [BOUND_W-1:0] hi;
    } window_t;

    typedef struct packed {
        logic              synced;
        logic              last_bit;
        logic              half_seen;
        logic [CNT_W-1:0]  bits_taken;
        logic              ext_frame;
        logic [CODE_W-1:0] shift_code;
    } dec_state_t;

    function automatic window_t make_window(input logic [BOUND_W-1:0] target,
                                            input logic [TOL_W-1:0]   tol);
        logic [BOUND_W:0] diff;
        window_t          w;
        diff     = {1'b0, target} - {{(BOUND_W + 1 - TOL_W){1'b0}}, tol};
        w.lo_neg = diff[BOUND_W];
        w.lo     = diff[BOUND_W-1:0];
        w.hi     = target + {{(BOUND_W - TOL_W){1'b0}}, tol};
        return w;
    endfunction

endpackage

`default_nettype wire

### rtl/core/rc5_pulse_decoder.sv
// rc5 and extended rc5 infrared decoder working on mark and space durations
`default_nettype none

// Takes one mark or space per transfer (tuser = is_mark, tdata = duration) and
// delivers a decoded frame (tdata = code word, tuser = extended flag) when the
// 14th or, for the extended variant, 20th bit is in. One item is taken every
// cycle while the output is not held; an item waits in the input register and
// its result is then registered in the result register that drives the output.
// While a result waits, one more item fits in the input register before
// s_tready drops. The timing windows for one, two and five units and the
// six-unit limit are kept in registers that are refreshed together with
// unit_length and tolerance, so each item only needs a handful of compares
// against its duration.
module rc5_pulse_decoder #(
    parameter int DURATION_BITS = 24
) (
    input  wire logic                                      aclk,
    input  wire logic                                      aresetn,

    input  wire logic                                      cfg_we,
    input  wire logic                                      cfg_index,
    input  wire logic [rc5pd_pkg::CFG_W-1:0]               cfg_wdata,

    input  wire logic                                      s_tvalid,
    output logic                                           s_tready,
    // duration
    input  wire logic [((DURATION_BITS+7)/8)*8-1:0]        s_tdata,
    // is_mark
    input  wire logic                                      s_tuser,

    output logic                                           m_tvalid,
    input  wire logic                                      m_tready,
    // code_word
    output logic [rc5pd_pkg::OUT_TDATA_W-1:0]              m_tdata,
    // extended
    output logic                                           m_tuser
);

    localparam int CW = (DURATION_BITS > rc5pd_pkg::BOUND_W) ? DURATION_BITS
                                                              : rc5pd_pkg::BOUND_W;
    localparam int BW = rc5pd_pkg::BOUND_W;

    // configuration and derived windows
    logic [rc5pd_pkg::UNIT_W-1:0] unit_reg, unit_next;
    logic [rc5pd_pkg::TOL_W-1:0]  tol_reg, tol_next;
    rc5pd_pkg::window_t           win1_reg, win2_reg, win5_reg;
    rc5pd_pkg::window_t           win1_next, win2_next, win5_next;
    logic [BW-1:0]                six_reg, six_next;
    logic [BW-1:0]                u1, u2, u4;

    always_comb begin
        unit_next = unit_reg;
        tol_next  = tol_reg;
        if (cfg_we) begin
            case (rc5pd_pkg::cfg_reg_t'(cfg_index))
                rc5pd_pkg::REG_UNIT_LENGTH: unit_next = cfg_wdata[rc5pd_pkg::UNIT_W-1:0];
                rc5pd_pkg::REG_TOLERANCE:   tol_next  = cfg_wdata[rc5pd_pkg::TOL_W-1:0];
                default: ;
            endcase
        end
        u1        = {{(BW - rc5pd_pkg::UNIT_W){1'b0}}, unit_next};
        u2        = u1 << 1;
        u4        = u1 << 2;
        win1_next = rc5pd_pkg::make_window(u1, tol_next);
        win2_next = rc5pd_pkg::make_window(u2, tol_next);
        win5_next = rc5pd_pkg::make_window(u4 + u1, tol_next);
        six_next  = u4 + u2;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            unit_reg <= rc5pd_pkg::UNIT_RESET;
            tol_reg  <= rc5pd_pkg::TOL_RESET;
            win1_reg <= rc5pd_pkg::make_window(
                            {{(BW - rc5pd_pkg::UNIT_W){1'b0}}, rc5pd_pkg::UNIT_RESET},
                            rc5pd_pkg::TOL_RESET);
            win2_reg <= rc5pd_pkg::make_window(
                            {{(BW - rc5pd_pkg::UNIT_W - 1){1'b0}}, rc5pd_pkg::UNIT_RESET,
                             1'b0},
                            rc5pd_pkg::TOL_RESET);
            win5_reg <= rc5pd_pkg::make_window(
                            {{(BW - rc5pd_pkg::UNIT_W - 2){1'b0}}, rc5pd_pkg::UNIT_RESET,
                             2'b00}
                            + {{(BW - rc5pd_pkg::UNIT_W){1'b0}}, rc5pd_pkg::UNIT_RESET},
                            rc5pd_pkg::TOL_RESET);
            six_reg  <= {{(BW - rc5pd_pkg::UNIT_W - 2){1'b0}}, rc5pd_pkg::UNIT_RESET, 2'b00}
                        + {{(BW - rc5pd_pkg::UNIT_W - 1){1'b0}}, rc5pd_pkg::UNIT_RESET,
                           1'b0};
        end else begin
            unit_reg <= unit_next;
            tol_reg  <= tol_next;
            win1_reg <= win1_next;
            win2_reg <= win2_next;
            win5_reg <= win5_next;
            six_reg  <= six_next;
        end
    end

    // input register
    logic                     in_valid_reg;
    logic                     mark_reg;
    logic [DURATION_BITS-1:0] dur_reg;
    logic                     step_en;
    logic                     out_free;

    assign out_free = !m_tvalid || m_tready;
    assign step_en  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || step_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            mark_reg <= s_tuser;
            dur_reg  <= s_tdata[DURATION_BITS-1:0];
        end
    end

    // window matching
    logic [CW-1:0] dur_ext;
    logic          near1, near2, near5, overlong;

    assign dur_ext  = CW'(dur_reg);
    assign near1    = (win1_reg.lo_neg || dur_ext >= CW'(win1_reg.lo)) &&
                      (dur_ext <= CW'(win1_reg.hi));
    assign near2    = (win2_reg.lo_neg || dur_ext >= CW'(win2_reg.lo)) &&
                      (dur_ext <= CW'(win2_reg.hi));
    assign near5    = (win5_reg.lo_neg || dur_ext >= CW'(win5_reg.lo)) &&
                      (dur_ext <= CW'(win5_reg.hi));
    assign overlong = dur_ext > CW'(six_reg);

    // decoder state update
    rc5pd_pkg::dec_state_t        st_reg, st_next, cur, work;
    logic                         sync_now;
    logic                         emit;
    logic                         keep_last;
    logic [rc5pd_pkg::CODE_W-1:0] res_code;
    logic                         res_ext;

    always_comb begin
        cur      = st_reg;
        sync_now = !st_reg.synced && mark_reg && near1;
        if (sync_now) begin
            cur.synced     = 1'b1;
            cur.last_bit   = 1'b1;
            cur.shift_code = rc5pd_pkg::CODE_W'(1);
            cur.bits_taken = st_reg.bits_taken + 1'b1;
        end
        work = cur;
        emit = 1'b0;
        if (overlong) begin
            work          = '0;
            work.last_bit = st_reg.last_bit;
        end else if (cur.synced) begin
            if (near2) begin
                work.last_bit   = ~cur.last_bit;
                work.bits_taken = cur.bits_taken + 1'b1;
                work.shift_code = {cur.shift_code[rc5pd_pkg::CODE_W-2:0], ~cur.last_bit};
            end else if (near1 && !cur.half_seen) begin
                work.half_seen = 1'b1;
            end else if (near1) begin
                work.half_seen  = 1'b0;
                work.bits_taken = cur.bits_taken + 1'b1;
                work.shift_code = {cur.shift_code[rc5pd_pkg::CODE_W-2:0], cur.last_bit};
            end else if (!cur.half_seen && near5 &&
                         cur.bits_taken == rc5pd_pkg::EXT_GAP_BITS) begin
                work.ext_frame = 1'b1;
                work.half_seen = 1'b1;
            end else begin
                work          = '0;
                work.last_bit = cur.last_bit;
            end
            emit = (!work.ext_frame && work.bits_taken == rc5pd_pkg::STD_FRAME_BITS) ||
                   (work.ext_frame && work.bits_taken == rc5pd_pkg::EXT_FRAME_BITS);
        end
        res_code  = work.shift_code;
        res_ext   = work.ext_frame;
        keep_last = work.last_bit;
        if (emit) begin
            work          = '0;
            work.last_bit = keep_last;
        end
        st_next = step_en ? work : st_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= '0;
        end else begin
            st_reg <= st_next;
        end
    end

    // result register
    logic                         m_valid_reg;
    logic [rc5pd_pkg::CODE_W-1:0] code_reg;
    logic                         ext_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (step_en) begin
            m_valid_reg <= emit;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en && emit) begin
            code_reg <= res_code;
            ext_reg  <= res_ext;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(rc5pd_pkg::OUT_TDATA_W - rc5pd_pkg::CODE_W){1'b0}}, code_reg};
    assign m_tuser  = ext_reg;

endmodule

`default_nettype wire

### tb/tb_rc5_pulse_decoder.sv
// self-checking testbench for the rc5 pulse decoder with a frame scoreboard
`timescale 1ns / 1ps

module tb_rc5_pulse_decoder;

    localparam int          DUR_W          = 24;
    localparam int          OVERLONG_UNITS = 6;
    localparam int          EXT_GAP_UNITS  = 5;
    localparam int          LIMIT_CYCLES   = 400000;
    localparam logic [23:0] DUR_MAX        = 24'hFFFFFF;

    typedef struct {
        logic [rc5pd_pkg::CODE_W-1:0] code;
        logic                         ext;
    } rc5_frame_t;

    class rc5_frame_scoreboard;
        logic [rc5pd_pkg::UNIT_W-1:0] unit;
        logic [rc5pd_pkg::TOL_W-1:0]  tol;
        logic                         synced;
        logic                         last_bit;
        logic                         half_seen;
        logic [rc5pd_pkg::CNT_W-1:0]  bits_taken;
        logic                         ext_frame;
        logic [rc5pd_pkg::CODE_W-1:0] shift_code;
        rc5_frame_t                   pending_frames[$];
        int                           errors;
        int                           intervals;
        int                           std_frames;
        int                           ext_frames;

        function new();
            unit       = rc5pd_pkg::UNIT_RESET;
            tol        = rc5pd_pkg::TOL_RESET;
            last_bit   = 1'b0;
            errors     = 0;
            intervals  = 0;
            std_frames = 0;
            ext_frames = 0;
            drop_frame();
        endfunction

        function void drop_frame();
            synced     = 1'b0;
            half_seen  = 1'b0;
            bits_taken = '0;
            ext_frame  = 1'b0;
            shift_code = '0;
        endfunction

        function bit hits_window(longint unsigned d, int k);
            longint unsigned target;
            longint unsigned diff;
            target = longint'(k) * longint'(unit);
            diff   = (d > target) ? d - target : target - d;
            return diff <= longint'(tol);
        endfunction

        function void shift_in();
            bits_taken = bits_taken + 1'b1;
            shift_code = {shift_code[rc5pd_pkg::CODE_W-2:0], last_bit};
        endfunction

        // predicts the decoder's response to one accepted mark or space
        function void take_interval(logic mark, logic [DUR_W-1:0] dur);
            longint unsigned d;
            rc5_frame_t      f;
            d = 64'(dur);
            intervals++;
            if (d > longint'(OVERLONG_UNITS) * longint'(unit)) begin
                drop_frame();
                return;
            end
            if (!synced && mark && hits_window(d, 1)) begin
                synced     = 1'b1;
                last_bit   = 1'b1;
                shift_code = rc5pd_pkg::CODE_W'(1);
                bits_taken = bits_taken + 1'b1;
            end
            if (!synced)
                return;
            if (hits_window(d, 2)) begin
                last_bit = ~last_bit;
                shift_in();
            end else if (hits_window(d, 1) && !half_seen) begin
                half_seen = 1'b1;
            end else if (hits_window(d, 1) && half_seen) begin
                half_seen = 1'b0;
                shift_in();
            end else if (half_seen) begin
                drop_frame();
            end else if (hits_window(d, EXT_GAP_UNITS) &&
                         bits_taken == rc5pd_pkg::EXT_GAP_BITS) begin
                ext_frame = 1'b1;
                half_seen = 1'b1;
            end else begin
                drop_frame();
            end
            if ((!ext_frame && bits_taken == rc5pd_pkg::STD_FRAME_BITS) ||
                (ext_frame && bits_taken == rc5pd_pkg::EXT_FRAME_BITS)) begin
                f.code = shift_code;
                f.ext  = ext_frame;
                pending_frames.push_back(f);
                if (ext_frame)
                    ext_frames++;
                else
                    std_frames++;
                drop_frame();
            end
        endfunction

        function void compare_frame(logic [rc5pd_pkg::CODE_W-1:0] code, logic ext);
            rc5_frame_t f;
            if (pending_frames.size() == 0) begin
                errors++;
                $display("%0t: unexpected frame code %h ext %0b", $time, code, ext);
                return;
            end
            f = pending_frames.pop_front();
            if (code !== f.code) begin
                errors++;
                $display("%0t: code_word expected %h actual %h", $time, f.code, code);
            end
            if (ext !== f.ext) begin
                errors++;
                $display("%0t: extended expected %0b actual %0b", $time, f.ext, ext);
            end
        endfunction
    endclass

    logic                              aclk      = 1'b0;
    logic                              aresetn   = 1'b0;
    logic                              cfg_we    = 1'b0;
    logic                              cfg_index = rc5pd_pkg::REG_UNIT_LENGTH;
    logic [rc5pd_pkg::CFG_W-1:0]       cfg_wdata = '0;
    logic                              s_tvalid  = 1'b0;
    logic                              s_tready;
    logic [DUR_W-1:0]                  s_tdata   = '0;
    logic                              s_tuser   = 1'b0;
    logic                              m_tvalid;
    logic                              m_tready  = 1'b0;
    logic [rc5pd_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic                              m_tuser;

    rc5_frame_scoreboard sb;
    int                  sent;
    int                  settings_run;
    int                  gap_pct;
    int                  stall_pct;
    bit                  calm;
    int                  stall_left;
    int                  cycles;

    rc5_pulse_decoder #(
        .DURATION_BITS(DUR_W)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT_CYCLES) begin
            $display("timeout with %0d frames still expected", sb.pending_frames.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (calm || stall_pct == 0) begin
            m_tready <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if ($urandom_range(0, 99) < stall_pct) begin
            stall_left <= $urandom_range(0, 17);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                sb.take_interval(s_tuser, s_tdata);
            if (m_tvalid && m_tready)
                sb.compare_frame(m_tdata[rc5pd_pkg::CODE_W-1:0], m_tuser);
        end
    end

    function automatic logic [DUR_W-1:0] clamp_dur(longint v);
        if (v < 0)
            return '0;
        if (v > longint'(DUR_MAX))
            return DUR_MAX;
        return v[DUR_W-1:0];
    endfunction

    // duration near k units, often right on a window edge
    function automatic logic [DUR_W-1:0] near_dur(int k);
        longint t;
        longint tl;
        t  = longint'(k) * longint'(sb.unit);
        tl = longint'(sb.tol);
        case ($urandom_range(0, 3))
            0: return clamp_dur(t);
            1: return clamp_dur(t + tl);
            2: return clamp_dur(t - tl);
            default: return clamp_dur(t - tl + longint'($urandom_range(0, 2 * tl)));
        endcase
    endfunction

    function automatic logic [DUR_W-1:0] noise_dur();
        longint t;
        t = longint'(sb.unit);
        case ($urandom_range(0, 5))
            0: return DUR_W'($urandom);
            1: return near_dur($urandom_range(0, 7));
            2: return clamp_dur(OVERLONG_UNITS * t + 1 + $urandom_range(0, 3));
            3: return DUR_MAX;
            4: return clamp_dur($urandom_range(1, 5) * t + longint'(sb.tol) + 1);
            default: return clamp_dur($urandom_range(0, 7 * t + 1));
        endcase
    endfunction

    task automatic send_interval(input logic mark, input logic [DUR_W-1:0] dur);
        int idle;
        if (!calm && $urandom_range(0, 99) < gap_pct) begin
            idle = $urandom_range(1, 18);
            s_tvalid <= 1'b0;
            repeat (idle) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mark;
        s_tdata  <= dur;
        do @(posedge aclk); while (!s_tready);
        sent++;
    endtask

    task automatic send_noise();
        send_interval(1'($urandom_range(0, 1)), noise_dur());
    endtask

    // manchester interval sequence for one frame, optionally cut short by noise
    task automatic send_frame(input bit want_ext, input int cut_at);
        int bits;
        int count;
        bit half;
        bit ext;
        bit mark;
        bits  = 1;
        count = 1;
        half  = 1'b1;
        ext   = 1'b0;
        mark  = 1'b1;
        send_interval(1'b1, near_dur(1));
        while (bits != (ext ? int'(rc5pd_pkg::EXT_FRAME_BITS)
                            : int'(rc5pd_pkg::STD_FRAME_BITS)) &&
               (cut_at == 0 || count < cut_at)) begin
            mark = !mark;
            count++;
            if (want_ext && !ext && bits == int'(rc5pd_pkg::EXT_GAP_BITS) && !half) begin
                send_interval(mark, near_dur(EXT_GAP_UNITS));
                ext  = 1'b1;
                half = 1'b1;
            end else if (want_ext && !ext && bits == int'(rc5pd_pkg::EXT_GAP_BITS) - 1) begin
                send_interval(mark, near_dur(half ? 1 : 2));
                bits++;
                half = 1'b0;
            end else if ($urandom_range(0, 1)) begin
                send_interval(mark, near_dur(2));
                bits++;
            end else begin
                send_interval(mark, near_dur(1));
                if (half)
                    bits++;
                half = !half;
            end
        end
        if (cut_at != 0)
            send_noise();
    endtask

    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.pending_frames.size() != 0);
    endtask

    task automatic set_timing(input logic [rc5pd_pkg::CFG_W-1:0] unit_word,
                              input logic [rc5pd_pkg::CFG_W-1:0] tol_word);
        hold_until_drained();
        repeat (4) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= rc5pd_pkg::REG_UNIT_LENGTH;
        cfg_wdata <= unit_word;
        @(posedge aclk);
        sb.unit = unit_word[rc5pd_pkg::UNIT_W-1:0];
        cfg_index <= rc5pd_pkg::REG_TOLERANCE;
        cfg_wdata <= tol_word;
        @(posedge aclk);
        sb.tol = tol_word[rc5pd_pkg::TOL_W-1:0];
        cfg_we <= 1'b0;
        repeat (2) @(posedge aclk);
        settings_run++;
    endtask

    task automatic run_phase(input logic [rc5pd_pkg::CFG_W-1:0] unit_word,
                             input logic [rc5pd_pkg::CFG_W-1:0] tol_word,
                             input int n, input int gap, input int stall);
        int  start;
        int  r;
        bit  held;
        set_timing(unit_word, tol_word);
        gap_pct   = gap;
        stall_pct = stall;
        start     = sent;
        held      = 1'b0;
        while (sent - start < n) begin
            r = $urandom_range(0, 99);
            if (r < 70)
                send_frame(1'($urandom_range(0, 1)), 0);
            else if (r < 85)
                send_frame(1'($urandom_range(0, 1)), $urandom_range(2, 24));
            else
                repeat ($urandom_range(1, 3)) send_noise();
            if (!held && sent - start > n / 2) begin
                hold_until_drained();
                held = 1'b1;
            end
        end
    endtask

    initial begin
        logic [rc5pd_pkg::UNIT_W-1:0] u;
        sb           = new();
        sent         = 0;
        settings_run = 1;
        gap_pct      = 20;
        stall_pct    = 20;
        calm         = 1'b0;
        stall_left   = 0;
        cycles       = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: extremes, sync then bad timing, one all-flip frame
        send_interval(1'b1, DUR_MAX);
        send_interval(1'b0, 24'd0);
        send_interval(1'b1, 24'd0);
        send_interval(1'b1, 24'd889);
        send_interval(1'b0, 24'd2667);
        send_interval(1'b1, 24'd889);
        repeat (13) send_interval(1'b0, 24'd1778);
        send_interval(1'b1, 24'd1189);
        send_interval(1'b0, 24'd588);

        run_phase({2'b11, 22'd889}, 24'd300, 240, 20, 20);
        run_phase(24'd1, 24'd0, 110, 40, 10);
        run_phase(24'd100, 24'd60, 110, 0, 30);
        run_phase(24'd2796202, 24'hFFFFFF, 70, 10, 10);
        run_phase(24'd0, 24'd5, 40, 20, 20);
        run_phase(24'h155555, rc5pd_pkg::CFG_W'($urandom_range(0, 400000)), 90, 15, 15);
        u = rc5pd_pkg::UNIT_W'($urandom_range(50, 5000));
        run_phase(rc5pd_pkg::CFG_W'(u), rc5pd_pkg::CFG_W'($urandom_range(0, u)),
                  120, 25, 25);
        calm = 1'b1;
        run_phase(24'd889, 24'd300, 250, 0, 0);

        hold_until_drained();
        repeat (8) @(posedge aclk);
        $display("checked %0d intervals under %0d timing settings", sb.intervals,
                 settings_run);
        $display("frames decoded: %0d standard, %0d extended", sb.std_frames,
                 sb.ext_frames);
        if (sb.errors == 0 && sb.pending_frames.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
